// ===== sv/mrpc_pkg.sv =====
// package: widths and sequencer codes for the primality checker
`default_nettype none
package mrpc_pkg;
  localparam int NUM_BITS = 32;
  localparam int CW = $clog2(NUM_BITS + 1);
  localparam int PW = 2 * NUM_BITS;
  typedef logic [NUM_BITS-1:0] val_t;
  typedef logic [PW-1:0] prod_t;
  typedef logic [CW-1:0] cnt_t;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_RED    = 9'b000000010,
    S_SPLIT  = 9'b000000100,
    S_EXP    = 9'b000001000,
    S_MUL    = 9'b000010000,
    S_MODW   = 9'b000100000,
    S_CHECK  = 9'b001000000,
    S_SQR    = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;
endpackage
`default_nettype wire

// ===== sv/mrpc_modmul.sv =====
// shared modular multiply unit: one multiply, then restoring reduction a bit per cycle
`default_nettype none
module mrpc_modmul (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire mrpc_pkg::val_t  op_a,
  input  wire mrpc_pkg::val_t  op_b,
  input  wire mrpc_pkg::val_t  modulus,
  output logic                 busy,
  output mrpc_pkg::val_t       result
);
  import mrpc_pkg::*;

  localparam int RW = NUM_BITS + 1;
  localparam int IW = $clog2(PW + 1);

  prod_t prod_r, prod_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [IW-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic [RW-1:0] shifted;

  // shift one product bit into the remainder, subtract modulus when it fits
  always_comb begin
    prod_nxt = prod_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    shifted = {rem_r[RW-2:0], prod_r[PW-1]};
    if (start) begin
      prod_nxt = PW'(op_a) * PW'(op_b);
      rem_nxt = '0;
      cnt_nxt = IW'(PW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      prod_nxt = {prod_r[PW-2:0], 1'b0};
      rem_nxt = (shifted >= {1'b0, modulus}) ? shifted - {1'b0, modulus} : shifted;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == IW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    prod_r <= prod_nxt;
    rem_r <= rem_nxt;
  end

  assign busy = busy_r | start;
  assign result = rem_r[NUM_BITS-1:0];
endmodule
`default_nettype wire

// ===== sv/miller_rabin_primality_check.sv =====
// top level: miller-rabin sequencer around the shared modular multiply unit
`default_nettype none
// Miller-Rabin check over a run of witness words, one witness per input word.
// With n-1 = d*2^r, each witness takes one reduction pass, popcount(d) +
// bits(d) square-and-multiply passes and up to r-1 squarings, at most 64
// passes through one modular multiply unit, each a bit-serial reduction.
// The block is not ready while a witness is tested, nor while a result is
// held by out_stall. A result word comes out only on the last witness.
module miller_rabin_primality_check (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [31:0]            in_candidate,
  input  wire logic [31:0]            in_witness,
  input  wire logic                   in_last_witness,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic                        out_probably_prime
);
  import mrpc_pkg::*;

  state_t state_r, state_nxt;
  val_t n_r, n_nxt, a_r, a_nxt, d_r, d_nxt, x_r, x_nxt;
  cnt_t r_r, r_nxt;
  logic last_r, last_nxt, comp_r, comp_nxt;
  logic ov_r, ov_nxt, op_r, op_nxt;
  logic mm_start, mm_busy;
  val_t mm_a, mm_b, mm_res, nm1;
  logic sqr_base_r, sqr_base_nxt;
  logic fail;

  mrpc_modmul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mm_start), .op_a(mm_a), .op_b(mm_b),
    .modulus(n_r), .busy(mm_busy), .result(mm_res)
  );

  assign nm1 = n_r - 1'b1;
  assign in_stall = (state_r != S_IDLE) || (ov_r && out_stall);
  assign out_valid = ov_r;
  assign out_probably_prime = op_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    n_nxt = n_r; a_nxt = a_r; d_nxt = d_r; x_nxt = x_r; r_nxt = r_r;
    last_nxt = last_r; comp_nxt = comp_r; ov_nxt = ov_r; op_nxt = op_r;
    sqr_base_nxt = sqr_base_r;
    mm_start = 1'b0; mm_a = a_r; mm_b = '1;
    fail = 1'b0;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          n_nxt = in_candidate[NUM_BITS-1:0];
          a_nxt = in_witness[NUM_BITS-1:0];
          last_nxt = in_last_witness;
          state_nxt = S_DONE;
          if (in_candidate[NUM_BITS-1:0] <= val_t'(1)) comp_nxt = 1'b1;
          else if (in_candidate[NUM_BITS-1:0] > val_t'(3)) state_nxt = S_RED;
        end
      end
      // a mod n as a*1 through the unit
      S_RED: begin
        mm_start = 1'b1; mm_a = a_r; mm_b = val_t'(1);
        state_nxt = S_MODW;
        sqr_base_nxt = 1'b0;
        d_nxt = nm1; r_nxt = '0;
      end
      S_MODW: begin
        if (!mm_busy) begin
          a_nxt = mm_res;
          if (mm_res == '0 || mm_res == val_t'(1) || mm_res == nm1) state_nxt = S_DONE;
          else state_nxt = S_SPLIT;
        end
      end
      // strip trailing zeros of n-1, one per cycle
      S_SPLIT: begin
        if (!d_r[0]) begin
          d_nxt = d_r >> 1; r_nxt = r_r + 1'b1;
        end else begin
          x_nxt = val_t'(1); state_nxt = S_EXP;
        end
      end
      // square-and-multiply: multiply step if bit set, then square base
      S_EXP: begin
        if (d_r == '0) begin
          if (x_r == val_t'(1) || x_r == nm1) state_nxt = S_DONE;
          else state_nxt = S_CHECK;
        end else if (d_r[0] && !sqr_base_r) begin
          mm_start = 1'b1; mm_a = x_r; mm_b = a_r; state_nxt = S_MUL;
        end else begin
          mm_start = 1'b1; mm_a = a_r; mm_b = a_r; state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (!mm_busy) begin
          state_nxt = S_EXP;
          if (d_r[0] && !sqr_base_r) begin
            x_nxt = mm_res; sqr_base_nxt = 1'b1;
          end else begin
            a_nxt = mm_res; d_nxt = d_r >> 1; sqr_base_nxt = 1'b0;
          end
        end
      end
      // up to r-1 squarings looking for n-1
      S_CHECK: begin
        if (r_r <= cnt_t'(1)) begin
          fail = 1'b1; state_nxt = S_DONE;
        end else begin
          mm_start = 1'b1; mm_a = x_r; mm_b = x_r; state_nxt = S_SQR;
        end
      end
      S_SQR: begin
        if (!mm_busy) begin
          x_nxt = mm_res; r_nxt = r_r - 1'b1;
          state_nxt = (mm_res == nm1) ? S_DONE : S_CHECK;
        end
      end
      S_DONE: begin
        if (!(ov_r && out_stall)) begin
          if (last_r) begin
            ov_nxt = 1'b1; op_nxt = ~comp_r; comp_nxt = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (fail) comp_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      comp_r <= 1'b0;
      ov_r <= 1'b0;
      sqr_base_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      comp_r <= comp_nxt;
      ov_r <= ov_nxt;
      sqr_base_r <= sqr_base_nxt;
    end
    n_r <= n_nxt; a_r <= a_nxt; d_r <= d_nxt; x_r <= x_nxt; r_r <= r_nxt;
    last_r <= last_nxt; op_r <= op_nxt;
  end
endmodule
`default_nettype wire
